/* design/dotted_version_parser_defines.svh */
// assertion macros for the dotted version parser
`ifndef DOTTED_VERSION_PARSER_DEFINES_SVH
`define DOTTED_VERSION_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge out of reset
`define DVP_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// implication property checked at every clock edge out of reset
`define DVP_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`else

`define DVP_ASSERT_NOW(lbl, cond, msg)
`define DVP_ASSERT_PROP(lbl, prop, msg)

`endif

`endif

/* design/dvp_pkg.sv */
// shared types and constants of the dotted version parser
package dvp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned FAM_W  = 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    localparam logic [1:0] PART_MAJOR = 2'd0;
    localparam logic [1:0] PART_MINOR = 2'd1;
    localparam logic [1:0] PART_PATCH = 2'd2;

    typedef enum logic [FAM_W-1:0] {
        FAM_INVALID = 3'd0,
        FAM_OUTSIDE = 3'd1,
        FAM_1_0     = 3'd2,
        FAM_1_1     = 3'd3,
        FAM_2_0     = 3'd4,
        FAM_2_1     = 3'd5
    } t_family;

    typedef struct packed {
        logic [1:0]       part_index;
        logic [NUM_W-1:0] accumulator;
        logic             part_started;
        logic             leading_zero;
        logic             error_seen;
        logic [NUM_W-1:0] major_hold;
        logic [NUM_W-1:0] minor_hold;
    } t_parse_state;

    typedef struct packed {
        logic             well_formed;
        t_family          family_code;
        logic [NUM_W-1:0] major_num;
        logic [NUM_W-1:0] minor_num;
        logic [NUM_W-1:0] patch_num;
        logic             patch_present;
    } t_result;

    localparam t_parse_state PARSE_CLEAR = '{
        part_index:   PART_MAJOR,
        accumulator:  '0,
        part_started: 1'b0,
        leading_zero: 1'b0,
        error_seen:   1'b0,
        major_hold:   '0,
        minor_hold:   '0
    };

endpackage

/* design/dvp_step.sv */
// per-character parse step: next parser state and the result of a final character
module dvp_step (
    input  dvp_pkg::t_parse_state           i_state,
    input  logic [dvp_pkg::CHAR_W-1:0]      i_char,
    input  logic                            i_last,
    output dvp_pkg::t_parse_state           o_state,
    output dvp_pkg::t_result                o_result
);

    logic                      w_digit;
    logic                      w_dot;
    logic [3:0]                w_d;
    logic [dvp_pkg::NUM_W+3:0] w_prod;
    logic                      w_ovf;
    logic                      w_ok;
    dvp_pkg::t_parse_state     w_upd;
    logic [dvp_pkg::NUM_W-1:0] w_maj;
    logic [dvp_pkg::NUM_W-1:0] w_min;

    assign w_digit = (i_char >= dvp_pkg::CHAR_ZERO) && (i_char <= dvp_pkg::CHAR_NINE);
    assign w_dot   = (i_char == dvp_pkg::CHAR_DOT);
    assign w_d     = 4'(i_char - dvp_pkg::CHAR_ZERO);

    // acc * 10 + d as acc*8 + acc*2 + d
    assign w_prod = {1'b0, i_state.accumulator, 3'b000}
                  + {3'b000, i_state.accumulator, 1'b0}
                  + {{dvp_pkg::NUM_W{1'b0}}, w_d};
    assign w_ovf  = |w_prod[dvp_pkg::NUM_W+3:dvp_pkg::NUM_W];

    always_comb begin
        w_upd = i_state;
        if (!i_state.error_seen) begin
            if (w_digit) begin
                if (i_state.leading_zero || w_ovf) begin
                    w_upd.error_seen = 1'b1;
                end else begin
                    if (!i_state.part_started && (w_d == 4'd0)) begin
                        w_upd.leading_zero = 1'b1;
                    end
                    w_upd.accumulator  = w_prod[dvp_pkg::NUM_W-1:0];
                    w_upd.part_started = 1'b1;
                end
            end else if (w_dot) begin
                if (!i_state.part_started || (i_state.part_index >= dvp_pkg::PART_PATCH)) begin
                    w_upd.error_seen = 1'b1;
                end else begin
                    if (i_state.part_index == dvp_pkg::PART_MAJOR) begin
                        w_upd.major_hold = i_state.accumulator;
                    end else begin
                        w_upd.minor_hold = i_state.accumulator;
                    end
                    w_upd.part_index   = i_state.part_index + 2'd1;
                    w_upd.accumulator  = '0;
                    w_upd.part_started = 1'b0;
                    w_upd.leading_zero = 1'b0;
                end
            end else begin
                // stray character
                w_upd.error_seen = 1'b1;
            end
        end
    end

    assign w_ok  = !w_upd.error_seen && w_upd.part_started
                && (w_upd.part_index != dvp_pkg::PART_MAJOR);
    assign w_maj = w_ok ? w_upd.major_hold : '0;
    assign w_min = !w_ok ? '0
                 : (w_upd.part_index == dvp_pkg::PART_MINOR) ? w_upd.accumulator
                 : w_upd.minor_hold;

    always_comb begin
        o_result               = '0;
        o_result.well_formed   = w_ok;
        o_result.major_num     = w_maj;
        o_result.minor_num     = w_min;
        o_result.family_code   = dvp_pkg::FAM_INVALID;
        if (w_ok) begin
            if (w_upd.part_index == dvp_pkg::PART_PATCH) begin
                o_result.patch_num     = w_upd.accumulator;
                o_result.patch_present = 1'b1;
            end
            if ((w_maj == 32'd1) && (w_min == 32'd0)) begin
                o_result.family_code = dvp_pkg::FAM_1_0;
            end else if ((w_maj == 32'd1) && (w_min == 32'd1)) begin
                o_result.family_code = dvp_pkg::FAM_1_1;
            end else if ((w_maj == 32'd2) && (w_min == 32'd0)) begin
                o_result.family_code = dvp_pkg::FAM_2_0;
            end else if ((w_maj == 32'd2) && (w_min == 32'd1)) begin
                o_result.family_code = dvp_pkg::FAM_2_1;
            end else begin
                o_result.family_code = dvp_pkg::FAM_OUTSIDE;
            end
        end
    end

    // a final character returns the parser to its cleared state
    assign o_state = i_last ? dvp_pkg::PARSE_CLEAR : w_upd;

endmodule

/* design/dvp_out_stage.sv */
// result register on the master side with its handshake
module dvp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dvp_pkg::t_result  i_result,
    output logic              o_full,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // major_num [31:0], minor_num [63:32], patch_num [95:64]
    output logic [95:0]       m_axis_tdata,
    // well_formed [0], family_code [3:1], patch_present [4], zero [7:5]
    output logic [7:0]        m_axis_tuser
);

    logic             r_valid;
    logic             n_valid;
    dvp_pkg::t_result r_result;

    // full when a result waits and is not taken this cycle
    assign o_full  = r_valid && !m_axis_tready;
    assign n_valid = i_load || (r_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_result.patch_num, r_result.minor_num, r_result.major_num};
    assign m_axis_tuser  = {3'b000, r_result.patch_present, r_result.family_code,
                            r_result.well_formed};

endmodule

/* design/dotted_version_parser.sv */
// top level of the streaming dotted version parser
//
// channel   dir  tdata             tuser                                  tlast
// s_axis    in   char_code [7:0]   -                                      last_char
// m_axis    out  major/minor/patch well_formed, family_code, patch_present -
//
// each character is held in the input register, where the parse step
// runs; a final character then loads the result register as it advances
// one character per cycle sustained while no final character waits on a held result
// a final character passes the input register and then the result register to m_axis
// synchronous active-low reset clears the parser state and both valid flags
// a result waiting on m_axis stalls a final character behind it, and with it the input;
// other characters keep flowing until a final one arrives
module dotted_version_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // char_code [7:0]
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // major_num [31:0], minor_num [63:32], patch_num [95:64]
    output logic [95:0]  m_axis_tdata,
    // well_formed [0], family_code [3:1], patch_present [4], zero [7:5]
    output logic [7:0]   m_axis_tuser
);

`include "dotted_version_parser_defines.svh"

    // input register
    logic                          r_in_valid;
    logic                          n_in_valid;
    logic [dvp_pkg::CHAR_W-1:0]    r_char;
    logic                          r_last;

    // parser state, advanced once per character
    dvp_pkg::t_parse_state         r_state;
    dvp_pkg::t_parse_state         w_state_next;
    dvp_pkg::t_result              w_result;

    logic                          w_out_full;
    logic                          w_advance;
    logic                          w_load;
    logic                          w_s_xfer;

    // a held character moves on unless it is final and the result slot is taken
    assign w_advance     = r_in_valid && !(r_last && w_out_full);
    assign w_load        = w_advance && r_last;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_xfer      = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = w_s_xfer || (r_in_valid && !w_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= dvp_pkg::PARSE_CLEAR;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_advance) begin
                r_state <= w_state_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    dvp_step u_step (
        .i_state  (r_state),
        .i_char   (r_char),
        .i_last   (r_last),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    dvp_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_result      (w_result),
        .o_full        (w_out_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a final character never lands on a result that is still waiting
    `DVP_ASSERT_NOW(a_no_overwrite, !(w_load && m_axis_tvalid && !m_axis_tready), "result overwritten")
    // a final character leaves the parser cleared for the next string
    `DVP_ASSERT_PROP(a_clear_after_last, (w_load |=> (r_state == dvp_pkg::PARSE_CLEAR)), "state not cleared")
    // an invalid result carries no family, numbers or patch flag
    `DVP_ASSERT_NOW(a_invalid_zero, !(m_axis_tvalid && !m_axis_tuser[0]) || ((m_axis_tuser[4:1] == 4'd0) && (m_axis_tdata == 96'd0)), "invalid result not zero")
    // a valid result always names a family
    `DVP_ASSERT_NOW(a_valid_family, !(m_axis_tvalid && m_axis_tuser[0]) || (m_axis_tuser[3:1] != 3'(dvp_pkg::FAM_INVALID)), "valid result without family")
    // the part counter never passes the patch part
    `DVP_ASSERT_NOW(a_part_range, r_state.part_index != 2'd3, "part index out of range")

endmodule
